[rtl/u8u16_pkg.sv]
// Package for the UTF-8 to UTF-16/UTF-32 transcoder.
// Holds the word types of both channels, the encoding constants and lead_class.
// No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

   // Input word: one UTF-8 byte and the end-of-string mark.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } u8u16_req_type;

   // Result word: one output unit and its two marks.
   typedef struct packed {
      logic [31:0] out_unit;
      logic        last_of_run;
      logic        string_done;
   } u8u16_rsp_type;

   // Lead classes taken from the top five bits of a byte.
   typedef enum logic [2:0] {
      CLS_CONT    = 3'd0,
      CLS_ONE     = 3'd1,
      CLS_TWO     = 3'd2,
      CLS_THREE   = 3'd3,
      CLS_FOUR    = 3'd4,
      CLS_INVALID = 3'd5
   } u8u16_class_type;

   localparam int unsigned MaxUnits = 4;

   localparam logic [31:0] Utf16Invalid = 32'h0000_003F;
   localparam logic [31:0] Utf32Invalid = 32'hFFFF_FFFF;
   localparam logic [20:0] PlaneOneBase = 21'h01_0000;
   localparam logic [20:0] CodeLimit    = 21'h11_0000;
   localparam logic [15:0] HighSurrBase = 16'hD800;
   localparam logic [15:0] LowSurrBase  = 16'hDC00;

   // Lead class of a byte.
   function automatic u8u16_class_type lead_class(input logic [7:0] b);
      u8u16_class_type cls;
      if (!b[7]) begin
         cls = CLS_ONE;
      end else if (!b[6]) begin
         cls = CLS_CONT;
      end else if (!b[5]) begin
         cls = CLS_TWO;
      end else if (!b[4]) begin
         cls = CLS_THREE;
      end else if (!b[3]) begin
         cls = CLS_FOUR;
      end else begin
         cls = CLS_INVALID;
      end
      return cls;
   endfunction

endpackage

[rtl/utf8_to_utf16_transcoder.sv]
// Top level of the UTF-8 to UTF-16/UTF-32 transcoder.
// Depends on u8u16_pkg for word types, lead classes and constants.
//
// Usage:
//   req_*  carries one UTF-8 byte per word with an end-of-string mark.
//   rsp_*  carries the output units: UTF-16 words (zero-extended) or UTF-32
//          code points, with last_of_run on the final unit a byte causes and
//          string_done on the final unit of the string.
//   csr_*  writes the output format (0 UTF-16, 1 UTF-32); always ready. It must
//          be written only while the block is idle; the block does not enforce it.
// Each accepted byte is decoded in the cycle it is taken; its units appear in
// a result buffer from the next cycle. A byte that gives one unit or none lets
// the next byte follow in every cycle while the receiver is ready. A byte that
// gives n units (up to four) holds the input until the last is being taken, as
// the buffer drains one unit per ready cycle through the single output port.
// Reset clears the open sequence, the format and the result buffer. When the
// receiver stalls, the current unit is held and req_ready stays low until the
// last unit of the buffer is being taken.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  u8u16_pkg::u8u16_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output u8u16_pkg::u8u16_rsp_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_wdata
);

   localparam int unsigned MaxUnitsIdx = u8u16_pkg::MaxUnits - 1;

   // Decoder state and configuration.
   logic        fmt_ff;
   logic [2:0]  exp_ff, exp_in;
   logic [1:0]  held_ff, held_in;
   logic [20:0] pp_ff, pp_in;

   // Result buffer: pending units, how many remain and the end mark.
   logic [31:0] units_ff [MaxUnitsIdx:0];
   logic [31:0] units_in [MaxUnitsIdx:0];
   logic [2:0]  cnt_ff, cnt_in;
   logic        eos_ff, eos_in;

   // Decode signals.
   logic                       accept;
   logic                       taken;
   logic [31:0]                inv_unit;
   logic [31:0]                dec_units [MaxUnitsIdx:0];
   logic [2:0]                 dec_count;
   logic                       is_open;
   logic                       is_cont;
   logic [2:0]                 held_next;
   logic [20:0]                pp_next;
   u8u16_pkg::u8u16_class_type cls;
   logic [20:0]                cp_off;
   logic [31:0]                enc_a;
   logic [31:0]                enc_b;
   logic                       enc_two;
   logic [1:0]                 flush_n;
   logic [31:0]                tail_unit;
   logic                       tail_valid;

   // Handshakes.
   assign csr_ready = 1'b1;
   assign rsp_valid = (cnt_ff != 3'd0);
   assign taken     = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_ready);
   assign accept    = req_valid && req_ready;

   assign rsp_data.out_unit    = units_ff[0];
   assign rsp_data.last_of_run = (cnt_ff == 3'd1);
   assign rsp_data.string_done = (cnt_ff == 3'd1) && eos_ff;

   assign inv_unit  = fmt_ff ? u8u16_pkg::Utf32Invalid : u8u16_pkg::Utf16Invalid;
   assign is_open   = (exp_ff != 3'd0);
   assign is_cont   = (req_data.in_byte[7:6] == 2'b10);
   assign held_next = {1'b0, held_ff} + 3'd1;
   assign pp_next   = {pp_ff[14:0], req_data.in_byte[5:0]};
   assign cls       = u8u16_pkg::lead_class(req_data.in_byte);
   assign cp_off    = pp_next - u8u16_pkg::PlaneOneBase;

   // Encoder for a completed code point.
   always_comb begin
      enc_a   = {11'd0, pp_next};
      enc_b   = u8u16_pkg::Utf16Invalid;
      enc_two = 1'b0;
      if (!fmt_ff && (pp_next >= u8u16_pkg::PlaneOneBase)) begin
         if (pp_next < u8u16_pkg::CodeLimit) begin
            enc_a   = {16'd0, u8u16_pkg::HighSurrBase + {6'd0, cp_off[19:10]}};
            enc_b   = {16'd0, u8u16_pkg::LowSurrBase + {6'd0, cp_off[9:0]}};
            enc_two = 1'b1;
         end else begin
            enc_a = u8u16_pkg::Utf16Invalid;
         end
      end
   end

   // Unit that a byte gives when taken as a lead.
   always_comb begin
      tail_unit  = inv_unit;
      tail_valid = 1'b1;
      case (cls) inside
         u8u16_pkg::CLS_ONE: tail_unit = {24'd0, req_data.in_byte};
         u8u16_pkg::CLS_CONT, u8u16_pkg::CLS_INVALID: tail_unit = inv_unit;
         default: tail_valid = req_data.end_of_string;
      endcase
   end

   assign flush_n = is_open ? held_ff : 2'd0;

   // Decode one byte into the units it gives and the next state.
   always_comb begin
      for (int i = 0; i <= MaxUnitsIdx; i++) begin
         dec_units[i] = inv_unit;
      end
      dec_count = 3'd0;
      exp_in    = exp_ff;
      held_in   = held_ff;
      pp_in     = pp_ff;
      if (is_open && is_cont) begin
         if (held_next >= exp_ff) begin
            // Sequence complete.
            dec_units[0] = enc_a;
            dec_units[1] = enc_b;
            dec_count    = enc_two ? 3'd2 : 3'd1;
            exp_in       = 3'd0;
            held_in      = 2'd0;
            pp_in        = 21'd0;
         end else if (req_data.end_of_string) begin
            // Truncated at the end: every held byte is invalid.
            dec_count = held_next;
            exp_in    = 3'd0;
            held_in   = 2'd0;
            pp_in     = 21'd0;
         end else begin
            held_in = held_next[1:0];
            pp_in   = pp_next;
         end
      end else begin
         // Flush any broken sequence, then take the byte as a lead.
         dec_units[flush_n] = tail_unit;
         dec_count          = {1'b0, flush_n} + {2'd0, tail_valid};
         exp_in             = 3'd0;
         held_in            = 2'd0;
         pp_in              = 21'd0;
         if (!tail_valid) begin
            exp_in  = cls;
            held_in = 2'd1;
            case (cls)
               u8u16_pkg::CLS_TWO:   pp_in = {16'd0, req_data.in_byte[4:0]};
               u8u16_pkg::CLS_THREE: pp_in = {17'd0, req_data.in_byte[3:0]};
               default:              pp_in = {18'd0, req_data.in_byte[2:0]};
            endcase
         end
      end
   end

   // Result buffer next values: load on accept, else shift on take.
   always_comb begin
      for (int i = 0; i <= MaxUnitsIdx; i++) begin
         units_in[i] = units_ff[i];
      end
      cnt_in = cnt_ff;
      eos_in = eos_ff;
      if (accept) begin
         for (int i = 0; i <= MaxUnitsIdx; i++) begin
            units_in[i] = dec_units[i];
         end
         cnt_in = dec_count;
         eos_in = req_data.end_of_string;
      end else if (taken) begin
         for (int i = 0; i < MaxUnitsIdx; i++) begin
            units_in[i] = units_ff[i + 1];
         end
         cnt_in = cnt_ff - 3'd1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= 1'b0;
         exp_ff  <= 3'd0;
         held_ff <= 2'd0;
         pp_ff   <= 21'd0;
         cnt_ff  <= 3'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            fmt_ff <= csr_wdata;
         end
         if (accept) begin
            exp_ff  <= exp_in;
            held_ff <= held_in;
            pp_ff   <= pp_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i <= MaxUnitsIdx; i++) begin
         units_ff[i] <= units_in[i];
      end
      eos_ff <= eos_in;
   end

   // The buffer never holds more units than a byte can give.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("result buffer count out of range");

   // An open sequence always holds fewer bytes than its length.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      (held_ff != 2'd0) |-> ((exp_ff != 3'd0) && ({1'b0, held_ff} < exp_ff)))
      else $error("held count inconsistent with expected length");

   // An end-marked byte leaves no sequence open and gives a result.
   a_eos_close: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.end_of_string) |=> ((exp_ff == 3'd0) && rsp_valid))
      else $error("end of string left a sequence open or no result");

   // A new byte is taken over pending units only as the last one leaves.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (accept && (cnt_ff != 3'd0)) |-> (rsp_ready && (cnt_ff == 3'd1)))
      else $error("byte accepted over pending units");

endmodule
